// ----- rtl/core/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the CAN command segmenter.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int BYTES_PER_FRAME_DEF = 7;
  localparam int FILL_W              = 3;   // payload bytes held, 0..7
  localparam int PKT_W               = 8;

  typedef enum logic [1:0] {
    PH_ADDR    = 2'd0,
    PH_FUNC    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       final_byte;
  } ccs_in_t;

  typedef struct packed {
    logic [15:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic        frame_closes_command;
  } ccs_out_t;

endpackage

// ----- rtl/core/ccs_assembler.sv -----
// ----------------------------------------------------------------------------
// ccs_assembler
// Command byte parser: tracks address/function/payload phase, gathers payload
// bytes and builds the frame that the current byte completes.
// ----------------------------------------------------------------------------
module ccs_assembler
  import ccs_pkg::*;
#(
  parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     byte_fire,
  input  ccs_in_t  byte_in,
  output logic     frame_emit,
  output ccs_out_t frame
);

  localparam int IDX_W = (BYTES_PER_FRAME > 1) ? $clog2(BYTES_PER_FRAME) : 1;

  phase_t             phase_r;
  logic [7:0]         addr_r;
  logic [7:0]         func_r;
  logic [FILL_W-1:0]  fill_r;
  logic [PKT_W-1:0]   pkt_r;
  logic [7:0]         store_r [BYTES_PER_FRAME];

  logic [FILL_W-1:0]  fill_inc;
  logic               group_full;
  logic               in_payload;
  logic [IDX_W-1:0]   wr_idx;

  assign fill_inc   = fill_r + FILL_W'(1);
  assign group_full = (fill_inc >= FILL_W'(BYTES_PER_FRAME));
  assign in_payload = (phase_r != PH_ADDR) && (phase_r != PH_FUNC);
  assign wr_idx     = fill_r[IDX_W-1:0];
  assign frame_emit = in_payload && (byte_in.final_byte || group_full);

  // Frame seen as if the incoming byte were already stored.
  always_comb begin
    frame = '0;
    frame.frame_id             = {addr_r, pkt_r};
    frame.frame_length         = {1'b0, fill_inc} + 4'd1;
    frame.frame_closes_command = byte_in.final_byte;
    frame.frame_payload[7:0]   = func_r;
    for (int n = 0; n < BYTES_PER_FRAME; n++) begin
      if (FILL_W'(n) < fill_r) begin
        frame.frame_payload[8*(n+1) +: 8] = store_r[n];
      end else if (FILL_W'(n) == fill_r) begin
        frame.frame_payload[8*(n+1) +: 8] = byte_in.cmd_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      addr_r  <= '0;
      func_r  <= '0;
      fill_r  <= '0;
      pkt_r   <= '0;
    end else if (byte_fire) begin
      case (phase_r)
        PH_ADDR: begin
          addr_r  <= byte_in.cmd_byte;
          fill_r  <= '0;
          pkt_r   <= '0;
          phase_r <= byte_in.final_byte ? PH_ADDR : PH_FUNC;
        end
        PH_FUNC: begin
          func_r <= byte_in.cmd_byte;
          if (byte_in.final_byte) begin
            // short command: drop it
            phase_r <= PH_ADDR;
            fill_r  <= '0;
            pkt_r   <= '0;
          end else begin
            phase_r <= PH_PAYLOAD;
          end
        end
        default: begin
          if (byte_in.final_byte) begin
            phase_r <= PH_ADDR;
            fill_r  <= '0;
            pkt_r   <= '0;
          end else if (group_full) begin
            fill_r <= '0;
            pkt_r  <= pkt_r + PKT_W'(1);
          end else begin
            fill_r <= fill_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire && in_payload) begin
      store_r[wr_idx] <= byte_in.cmd_byte;
    end
  end

endmodule

// ----- rtl/core/can_command_segmenter.sv -----
// ----------------------------------------------------------------------------
// can_command_segmenter
// Splits a byte-serial command into extended-id CAN frames of up to
// BYTES_PER_FRAME payload bytes plus the function code.
// ----------------------------------------------------------------------------
//   channel  | ports                       | moves
//   ---------+-----------------------------+------------------------------
//   input    | in_valid in_ready in_data   | one command byte + last mark
//   output   | out_valid out_ready out_data| one frame
//
// One byte per cycle while in_ready is high; a completed frame is registered
// into the output register, or the skid entry if that is held. The output
// is a two-entry buffer, so in_ready drops only when both entries are full.
// Synchronous active-low reset returns the parser to expecting an address
// and empties the output buffer.
// ----------------------------------------------------------------------------
module can_command_segmenter
  import ccs_pkg::*;
#(
  parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ccs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ccs_out_t out_data
);

  logic     in_fire;
  logic     out_fire;
  logic     frame_emit;
  ccs_out_t frame;
  logic     push;

  logic     out_valid_r;
  ccs_out_t out_data_r;
  logic     skid_valid_r;
  ccs_out_t skid_data_r;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && out_ready;
  assign push      = in_fire && frame_emit;

  ccs_assembler #(
    .BYTES_PER_FRAME (BYTES_PER_FRAME)
  ) u_assembler (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (in_fire),
    .byte_in    (in_data),
    .frame_emit (frame_emit),
    .frame      (frame)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no push possible while the skid entry is occupied
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= frame;
      end else begin
        skid_data_r <= frame;
      end
    end
  end

endmodule

// ----- rtl/core/ccs_checker.sv -----
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks for the CAN command segmenter.
// ----------------------------------------------------------------------------
module ccs_checker
  import ccs_pkg::*;
#(
  parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input ccs_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input ccs_out_t out_data
);

  // stalled byte must hold
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input byte changed while stalled");

  // stalled frame must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output frame changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_length >= 4'd2) && (out_data.frame_length <= 4'd8))
    else $error("frame length out of range");

  // a frame that does not close the command carries a full group
  a_full_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_closes_command |->
      out_data.frame_length == 4'(BYTES_PER_FRAME + 1))
    else $error("partial frame before end of command");

  // input only backs up behind a waiting frame
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind can_command_segmenter ccs_checker #(
  .BYTES_PER_FRAME (BYTES_PER_FRAME)
) u_ccs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- dv/tb_can_command_segmenter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_can_command_segmenter
// Drives byte-serial commands into the segmenter, predicts each CAN frame
// in a local model of the parser, and checks every frame that leaves.
// ----------------------------------------------------------------------------
module tb_can_command_segmenter;
  import ccs_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ccs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ccs_out_t out_data;

  can_command_segmenter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ccs_in_t     bytes_pending[$];
  ccs_out_t    frames_due[$];
  int unsigned mismatches = 0;
  int unsigned cyc = 0;
  logic        idle_ok;

  // no random idling on either side inside this window
  assign idle_ok = !(cyc >= 800 && cyc < 1600);

  always @(posedge clk) cyc <= cyc + 1;

  // parser state of the prediction
  phase_t     seg_phase = PH_ADDR;
  logic [7:0] seg_addr = '0;
  logic [7:0] seg_func = '0;
  logic [7:0] seg_store [BYTES_PER_FRAME_DEF];
  int         seg_fill = 0;
  logic [7:0] seg_pkt = '0;

  task automatic emit_frame(input logic closes);
    ccs_out_t f;
    f.frame_id             = {seg_addr, seg_pkt};
    f.frame_length         = 4'(seg_fill + 1);
    f.frame_payload        = 64'(seg_func);
    for (int n = 0; n < seg_fill; n++)
      f.frame_payload[8*(n+1) +: 8] = seg_store[n];
    f.frame_closes_command = closes;
    frames_due.push_back(f);
    seg_pkt  = seg_pkt + 8'd1;
    seg_fill = 0;
  endtask

  task automatic segment_byte(input ccs_in_t b);
    case (seg_phase)
      PH_ADDR: begin
        seg_addr = b.cmd_byte;
        seg_fill = 0;
        seg_pkt  = '0;
        seg_phase = b.final_byte ? PH_ADDR : PH_FUNC;
      end
      PH_FUNC: begin
        seg_func = b.cmd_byte;
        if (b.final_byte) begin
          seg_phase = PH_ADDR;
          seg_fill  = 0;
          seg_pkt   = '0;
        end else begin
          seg_phase = PH_PAYLOAD;
        end
      end
      default: begin
        seg_store[seg_fill] = b.cmd_byte;
        seg_fill = seg_fill + 1;
        if (b.final_byte) begin
          emit_frame(1'b1);
          seg_phase = PH_ADDR;
          seg_pkt   = '0;
        end else if (seg_fill >= BYTES_PER_FRAME_DEF) begin
          emit_frame(1'b0);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // mode 0: random bytes with extremes mixed in, 1: all zero, 2: all ones
  task automatic queue_command(input int len, input int mode);
    ccs_in_t b;
    int      r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      case (mode)
        1:       b.cmd_byte = 8'h00;
        2:       b.cmd_byte = 8'hff;
        default: b.cmd_byte = (r < 8) ? 8'h00 : (r < 16) ? 8'hff : 8'($urandom);
      endcase
      b.final_byte = (i == len - 1);
      bytes_pending.push_back(b);
    end
  endtask

  // driver: the payload holds until its transfer
  always @(posedge clk) begin : drive
    logic    nv;
    ccs_in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        segment_byte(in_data);
        nv = 1'b0;
      end
      if (!nv && bytes_pending.size() > 0 && !(idle_ok && $urandom_range(99) < 37)) begin
        nd = bytes_pending.pop_front();
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // monitor
  always @(posedge clk) begin : watch
    ccs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        report_mismatch("unexpected frame id", 64'(out_data.frame_id), '0);
      end else begin
        want = frames_due.pop_front();
        if (out_data.frame_id !== want.frame_id)
          report_mismatch("frame_id", 64'(out_data.frame_id), 64'(want.frame_id));
        if (out_data.frame_length !== want.frame_length)
          report_mismatch("frame_length", 64'(out_data.frame_length),
                          64'(want.frame_length));
        if (out_data.frame_payload !== want.frame_payload)
          report_mismatch("frame_payload", out_data.frame_payload, want.frame_payload);
        if (out_data.frame_closes_command !== want.frame_closes_command)
          report_mismatch("frame_closes_command", 64'(out_data.frame_closes_command),
                          64'(want.frame_closes_command));
      end
    end
    out_ready <= rst_n && !(idle_ok && $urandom_range(99) < 37);
  end

  initial begin
    int r;
    int len;
    int random_items;
    int waited;
    // directed: short commands, minimal frame, group full on last byte,
    // group full before the end
    queue_command(1, 2);
    queue_command(2, 1);
    queue_command(3, 2);
    queue_command(9, 0);
    queue_command(10, 2);
    random_items = 0;
    while (random_items < 1575) begin
      r = $urandom_range(99);
      if (r < 10)      len = $urandom_range(1, 2);
      else if (r < 25) len = 2 + 7 * $urandom_range(1, 3);
      else if (r < 35) len = 2 + 7 * $urandom_range(1, 3) + 1;
      else             len = $urandom_range(3, 24);
      queue_command(len, (r % 20 == 0) ? 1 : (r % 20 == 1) ? 2 : 0);
      random_items += len;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_pending.size() > 0 || in_valid) @(negedge clk);
    waited = 0;
    while (frames_due.size() > 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (frames_due.size() > 0)
      report_mismatch("frames never delivered", 64'(frames_due.size()), '0);
    if (mismatches == 0) begin
      $display("can_command_segmenter regression: pass");
    end else begin
      $display("can_command_segmenter regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("can_command_segmenter regression: fail");
    $finish;
  end

endmodule
